// ===== sv/tvw_pkg.sv =====
// Package for the teleoperation velocity watchdog: payload structs,
// command and action codes, configuration register map and limits.
// No dependencies; every other file refers to it by scoped names.
package tvw_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_EN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_TICKS = 2'd3;

    // Configuration reset values
    localparam logic [14:0] MAX_LINEAR_RST     = 15'd256;
    localparam logic [14:0] MAX_ANGULAR_RST    = 15'd256;
    localparam logic        REVERSE_EN_RST     = 1'b0;
    localparam logic [15:0] WATCHDOG_TICKS_RST = 16'd500;

    // Event codes
    localparam logic [2:0] CMD_SESSION_START = 3'd0;
    localparam logic [2:0] CMD_SESSION_STOP  = 3'd1;
    localparam logic [2:0] CMD_VELOCITY      = 3'd2;
    localparam logic [2:0] CMD_CLEAR         = 3'd3;
    localparam logic [2:0] CMD_TICK          = 3'd4;

    // Tick decision codes
    localparam logic [1:0] ACT_NONE         = 2'd0;
    localparam logic [1:0] ACT_PUBLISH_VEL  = 2'd1;
    localparam logic [1:0] ACT_PUBLISH_ZERO = 2'd2;

    // Saturating tick timer
    localparam int          TIMER_W   = 17;
    localparam logic [16:0] TIMER_MAX = 17'h1_FFFF;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] linear_in;
        logic signed [15:0] angular_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] linear_out;
        logic signed [15:0] angular_out;
        logic               session_ended;
        logic               session_open;
        logic               is_idle;
    } out_item_t;

    typedef struct packed {
        logic [14:0] max_linear;
        logic [14:0] max_angular;
        logic        reverse_en;
        logic [15:0] watchdog_ticks;
    } cfg_t;

endpackage

// ===== sv/tvw_cfg_regs.sv =====
// Configuration register file of the velocity watchdog.
// Depends on tvw_pkg for the register map, reset values and cfg_t.
module tvw_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tvw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tvw_pkg::cfg_t                    cfg
);

    tvw_pkg::cfg_t cfg_reg;
    tvw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tvw_pkg::REG_MAX_LINEAR:     cfg_next.max_linear     = cfg_data[14:0];
                tvw_pkg::REG_MAX_ANGULAR:    cfg_next.max_angular    = cfg_data[14:0];
                tvw_pkg::REG_REVERSE_EN:     cfg_next.reverse_en     = cfg_data[0];
                tvw_pkg::REG_WATCHDOG_TICKS: cfg_next.watchdog_ticks = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_linear     <= tvw_pkg::MAX_LINEAR_RST;
            cfg_reg.max_angular    <= tvw_pkg::MAX_ANGULAR_RST;
            cfg_reg.reverse_en     <= tvw_pkg::REVERSE_EN_RST;
            cfg_reg.watchdog_ticks <= tvw_pkg::WATCHDOG_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tvw_core.sv =====
// Watchdog state and single-pass event logic: session count, held velocity,
// tick timer and flags. Depends on tvw_pkg for codes, limits and structs.
module tvw_core #(
    parameter int MAX_SESSIONS = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  tvw_pkg::in_item_t  item,
    input  tvw_pkg::cfg_t      cfg,
    output tvw_pkg::out_item_t result
);

    // Session counter is 8 bits, so the cap never exceeds 255
    localparam int          SESSION_CAP_INT = (MAX_SESSIONS < 255) ? MAX_SESSIONS : 255;
    localparam logic [7:0]  SESSION_CAP     = 8'(SESSION_CAP_INT);

    logic [7:0]                     open_sessions_reg, open_sessions_next;
    logic signed [15:0]             held_linear_reg, held_linear_next;
    logic signed [15:0]             held_angular_reg, held_angular_next;
    logic [tvw_pkg::TIMER_W-1:0]    timer_reg, timer_next;
    logic                           live_reg, live_next;
    logic                           zero_sent_reg, zero_sent_next;
    logic [1:0]                     action;
    logic                           ended;
    logic [7:0]                     sessions_dec;

    logic signed [16:0] lin_ext, ang_ext;
    logic signed [16:0] lin_hi, lin_lo, ang_hi, ang_lo;
    logic signed [16:0] lin_clamp, ang_clamp;

    // Clamp both axes against the configured limits
    always_comb
    begin
        lin_ext = {item.linear_in[15], item.linear_in};
        ang_ext = {item.angular_in[15], item.angular_in};
        lin_hi  = {2'b00, cfg.max_linear};
        lin_lo  = cfg.reverse_en ? -lin_hi : 17'sd0;
        ang_hi  = {2'b00, cfg.max_angular};
        ang_lo  = -ang_hi;
        if (lin_ext < lin_lo)
            lin_clamp = lin_lo;
        else if (lin_ext > lin_hi)
            lin_clamp = lin_hi;
        else
            lin_clamp = lin_ext;
        if (ang_ext < ang_lo)
            ang_clamp = ang_lo;
        else if (ang_ext > ang_hi)
            ang_clamp = ang_hi;
        else
            ang_clamp = ang_ext;
    end

    assign sessions_dec = (open_sessions_reg != 8'd0) ? open_sessions_reg - 8'd1 : 8'd0;

    always_comb
    begin
        open_sessions_next = open_sessions_reg;
        held_linear_next   = held_linear_reg;
        held_angular_next  = held_angular_reg;
        timer_next         = timer_reg;
        live_next          = live_reg;
        zero_sent_next     = zero_sent_reg;
        action             = tvw_pkg::ACT_NONE;
        ended              = 1'b0;
        unique case (item.cmd)
            tvw_pkg::CMD_SESSION_START:
            begin
                if (open_sessions_reg < SESSION_CAP)
                    open_sessions_next = open_sessions_reg + 8'd1;
            end
            tvw_pkg::CMD_SESSION_STOP:
            begin
                open_sessions_next = sessions_dec;
                if (sessions_dec == 8'd0)
                begin
                    held_linear_next  = '0;
                    held_angular_next = '0;
                    live_next         = 1'b0;
                    zero_sent_next    = 1'b1;
                    ended             = 1'b1;
                end
            end
            tvw_pkg::CMD_VELOCITY:
            begin
                held_linear_next  = lin_clamp[15:0];
                held_angular_next = ang_clamp[15:0];
                timer_next        = '0;
                live_next         = 1'b1;
                zero_sent_next    = 1'b0;
            end
            tvw_pkg::CMD_CLEAR:
            begin
                held_linear_next  = '0;
                held_angular_next = '0;
                live_next         = 1'b0;
                zero_sent_next    = 1'b1;
            end
            tvw_pkg::CMD_TICK:
            begin
                // Advance the timer first, then judge freshness on the new count
                if (timer_reg != tvw_pkg::TIMER_MAX)
                    timer_next = timer_reg + 17'd1;
                if (open_sessions_reg != 8'd0)
                begin
                    if (live_reg && (timer_next <= {1'b0, cfg.watchdog_ticks}))
                    begin
                        action = tvw_pkg::ACT_PUBLISH_VEL;
                    end
                    else if (!zero_sent_reg)
                    begin
                        held_linear_next  = '0;
                        held_angular_next = '0;
                        live_next         = 1'b0;
                        zero_sent_next    = 1'b1;
                        action            = tvw_pkg::ACT_PUBLISH_ZERO;
                    end
                end
            end
            default:
            begin
                action = tvw_pkg::ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_sessions_reg <= '0;
            held_linear_reg   <= '0;
            held_angular_reg  <= '0;
            timer_reg         <= '0;
            live_reg          <= 1'b0;
            zero_sent_reg     <= 1'b1;
        end
        else if (fire)
        begin
            open_sessions_reg <= open_sessions_next;
            held_linear_reg   <= held_linear_next;
            held_angular_reg  <= held_angular_next;
            timer_reg         <= timer_next;
            live_reg          <= live_next;
            zero_sent_reg     <= zero_sent_next;
        end
    end

    always_comb
    begin
        result.action         = action;
        result.linear_out     = held_linear_next;
        result.angular_out    = held_angular_next;
        result.session_ended  = ended;
        result.session_open   = (open_sessions_next != 8'd0);
        result.is_idle        = (open_sessions_next == 8'd0) && !live_next;
    end

endmodule

// ===== sv/teleop_velocity_watchdog.sv =====
// Top level of the teleoperation velocity watchdog: input register, result
// register and handshake. Depends on tvw_pkg, tvw_cfg_regs and tvw_core.
//
// Usage:
//   Command channel (cmd_valid, cmd_stall, cmd_data) carries one event per
//   transfer: session start, session stop, velocity command, clear or tick.
//   Result channel (res_valid, res_stall, res_data) returns exactly one
//   result per event, in event order.
//   Configuration port (cfg_wr_en, cfg_index, cfg_data) writes one register
//   per cycle; write only while no event is in flight.
// Timing:
//   An event transfers into the input register and is evaluated from there
//   into the result register once that register is free, which raises
//   res_valid. One event per cycle is sustained while res_stall stays low.
// Reset:
//   rst_n clears both pipeline valids, zeroes the session count, held
//   velocity and timer, marks zero as already sent, and loads the
//   configuration reset values.
// Stall:
//   While res_stall holds a result, the result register keeps it and one more
//   event may still transfer into the input register; further events are
//   stalled until the result transfers.
module teleop_velocity_watchdog #(
    parameter int MAX_SESSIONS = 255
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  tvw_pkg::in_item_t              cmd_data,
    output logic                           res_valid,
    input  logic                           res_stall,
    output tvw_pkg::out_item_t             res_data,
    input  logic                           cfg_wr_en,
    input  logic [tvw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvw_pkg::CFG_DATA_W-1:0] cfg_data
);

    tvw_pkg::cfg_t      cfg;
    tvw_pkg::out_item_t core_result;

    logic               s1_valid_reg;
    tvw_pkg::in_item_t  s1_item_reg;
    logic               res_valid_reg;
    tvw_pkg::out_item_t res_item_reg;

    logic res_free;
    logic fire;

    // Result register can take a new value when empty or draining
    assign res_free  = !res_valid_reg || !res_stall;
    // Evaluate the held event when its result has somewhere to go
    assign fire      = s1_valid_reg && res_free;
    assign cmd_stall = s1_valid_reg && !res_free;

    tvw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tvw_core #(
        .MAX_SESSIONS (MAX_SESSIONS)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Input register: load on every cycle the channel is not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            s1_item_reg <= cmd_data;
        end
    end

    // Result register: hold while stalled, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_item_reg <= core_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

endmodule

// ===== sv/tvw_checker.sv =====
// Port-level checker for the velocity watchdog, attached by bind.
// Depends on tvw_pkg for codes and structs and on the top level's ports.
module tvw_port_props
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input tvw_pkg::out_item_t res_data
);

    // Hold a stalled result until it transfers
    a_res_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("result payload changed while stalled");

    // A republish only happens with a session open
    a_publish_needs_session: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.action == tvw_pkg::ACT_PUBLISH_VEL) |-> res_data.session_open)
        else $error("velocity published with no open session");

    // A zero publish leaves the held velocity cleared and a session still open
    a_zero_publish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.action == tvw_pkg::ACT_PUBLISH_ZERO)
        |-> (res_data.linear_out == 16'sd0) && (res_data.angular_out == 16'sd0)
            && res_data.session_open)
        else $error("zero publish with nonzero held velocity");

    // End of the last session leaves the block idle
    a_end_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.session_ended |-> res_data.is_idle && !res_data.session_open)
        else $error("session ended but block not idle");

endmodule

bind teleop_velocity_watchdog tvw_port_props u_tvw_port_props
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

// ===== tb/sv/tvw_checker.sv =====
// Result checker for the teleoperation velocity watchdog: watches the command,
// result and configuration ports, predicts each result and compares it.
// Depends on tvw_pkg for the payload structs, codes and reset values.
module tvw_checker #(
    parameter int MAX_SESSIONS = 255
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_stall,
    input  tvw_pkg::in_item_t              cmd_data,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  tvw_pkg::out_item_t             res_data,
    input  logic                           cfg_wr_en,
    input  logic [tvw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvw_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending
);

    localparam logic [7:0] SESSION_CAP = (MAX_SESSIONS < 255) ? 8'(MAX_SESSIONS) : 8'd255;

    // Shadow copy of the configuration registers
    logic [14:0] lim_linear  = tvw_pkg::MAX_LINEAR_RST;
    logic [14:0] lim_angular = tvw_pkg::MAX_ANGULAR_RST;
    logic        reverse_ok  = tvw_pkg::REVERSE_EN_RST;
    logic [15:0] fresh_ticks = tvw_pkg::WATCHDOG_TICKS_RST;

    // Shadow copy of the watchdog state
    logic [7:0]                  sessions  = '0;
    logic signed [15:0]          held_lin  = '0;
    logic signed [15:0]          held_ang  = '0;
    logic [tvw_pkg::TIMER_W-1:0] tick_age  = '0;
    logic                        cmd_live  = 1'b0;
    logic                        zero_sent = 1'b1;

    tvw_pkg::out_item_t due_status[$];
    int                 fault_total = 0;

    function automatic logic signed [15:0] clamp_speed(input logic signed [15:0] v,
                                                       input logic signed [16:0] lo,
                                                       input logic signed [16:0] hi);
        logic signed [16:0] w;
        w = v;
        if (w < lo)
            w = lo;
        else if (w > hi)
            w = hi;
        return w[15:0];
    endfunction

    function automatic void drop_hold();
        held_lin  = '0;
        held_ang  = '0;
        cmd_live  = 1'b0;
        zero_sent = 1'b1;
    endfunction

    // Apply one event to the shadow state and return the status it reports
    function automatic tvw_pkg::out_item_t next_status(input tvw_pkg::in_item_t ev);
        tvw_pkg::out_item_t r;
        logic signed [16:0] lin_hi;
        logic signed [16:0] lin_lo;
        logic signed [16:0] ang_hi;
        r = '0;
        r.action = tvw_pkg::ACT_NONE;
        case (ev.cmd)
            tvw_pkg::CMD_SESSION_START:
            begin
                if (sessions < SESSION_CAP)
                    sessions = sessions + 8'd1;
            end
            tvw_pkg::CMD_SESSION_STOP:
            begin
                if (sessions != 8'd0)
                    sessions = sessions - 8'd1;
                if (sessions == 8'd0)
                begin
                    drop_hold();
                    r.session_ended = 1'b1;
                end
            end
            tvw_pkg::CMD_VELOCITY:
            begin
                lin_hi    = {2'b00, lim_linear};
                lin_lo    = reverse_ok ? -lin_hi : 17'sd0;
                ang_hi    = {2'b00, lim_angular};
                held_lin  = clamp_speed(ev.linear_in, lin_lo, lin_hi);
                held_ang  = clamp_speed(ev.angular_in, -ang_hi, ang_hi);
                tick_age  = '0;
                cmd_live  = 1'b1;
                zero_sent = 1'b0;
            end
            tvw_pkg::CMD_CLEAR:
                drop_hold();
            tvw_pkg::CMD_TICK:
            begin
                if (tick_age != tvw_pkg::TIMER_MAX)
                    tick_age = tick_age + 1'b1;
                if (sessions != 8'd0)
                begin
                    if (cmd_live && tick_age <= {1'b0, fresh_ticks})
                        r.action = tvw_pkg::ACT_PUBLISH_VEL;
                    else if (!zero_sent)
                    begin
                        drop_hold();
                        r.action = tvw_pkg::ACT_PUBLISH_ZERO;
                    end
                end
            end
            default:
                ;
        endcase
        r.linear_out     = held_lin;
        r.angular_out    = held_ang;
        r.session_open   = (sessions != 8'd0);
        r.is_idle        = (sessions == 8'd0) && !cmd_live;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fault_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tvw_pkg::out_item_t want;
        if (!rst_n)
        begin
            lim_linear  = tvw_pkg::MAX_LINEAR_RST;
            lim_angular = tvw_pkg::MAX_ANGULAR_RST;
            reverse_ok  = tvw_pkg::REVERSE_EN_RST;
            fresh_ticks = tvw_pkg::WATCHDOG_TICKS_RST;
            sessions    = '0;
            held_lin    = '0;
            held_ang    = '0;
            tick_age    = '0;
            cmd_live    = 1'b0;
            zero_sent   = 1'b1;
            due_status.delete();
        end
        else
        begin
            // Compare the outgoing transfer against the oldest prediction
            if (res_valid && !res_stall)
            begin
                if (due_status.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none actual %h",
                             $time, res_data);
                    fault_total++;
                end
                else
                begin
                    want = due_status.pop_front();
                    check_field("action", 16'(want.action), 16'(res_data.action));
                    check_field("linear_out", want.linear_out, res_data.linear_out);
                    check_field("angular_out", want.angular_out, res_data.angular_out);
                    check_field("session_ended", 16'(want.session_ended),
                                16'(res_data.session_ended));
                    check_field("session_open", 16'(want.session_open),
                                16'(res_data.session_open));
                    check_field("is_idle", 16'(want.is_idle), 16'(res_data.is_idle));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tvw_pkg::REG_MAX_LINEAR:     lim_linear  = cfg_data[14:0];
                    tvw_pkg::REG_MAX_ANGULAR:    lim_angular = cfg_data[14:0];
                    tvw_pkg::REG_REVERSE_EN:     reverse_ok  = cfg_data[0];
                    tvw_pkg::REG_WATCHDOG_TICKS: fresh_ticks = cfg_data;
                    default:                     ;
                endcase
            end
            if (cmd_valid && !cmd_stall)
                due_status.push_back(next_status(cmd_data));
        end
        pending    <= due_status.size();
        mismatches <= fault_total;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the teleoperation velocity watchdog: clock, reset,
// event and configuration stimulus, idling on both channels and the verdict.
// Depends on tvw_pkg, tvw_checker and the teleop_velocity_watchdog RTL.
module tb_top;

    localparam int SESSIONS_MAX = 255;
    // Longest legal stretch without a transfer is a stall burst plus a send
    // gap plus the input and result registers and a config write; allow many times that.
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cmd_valid = 1'b0;
    logic                           cmd_stall;
    tvw_pkg::in_item_t              cmd_data  = '0;
    logic                           res_valid;
    logic                           res_stall = 1'b0;
    tvw_pkg::out_item_t             res_data;
    logic                           cfg_wr_en = 1'b0;
    logic [tvw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tvw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;

    // Stimulus controls: quiet turns off idling on both sides
    logic        quiet        = 1'b0;
    int          gap_pct      = 20;
    int          events_sent  = 0;
    int          stall_left   = 0;
    int          stuck_cycles = 0;

    // Stimulus-side copy of the limits, used to aim speeds and tick runs
    logic [14:0] lim_lin = tvw_pkg::MAX_LINEAR_RST;
    logic [14:0] lim_ang = tvw_pkg::MAX_ANGULAR_RST;
    logic [15:0] cur_wd  = tvw_pkg::WATCHDOG_TICKS_RST;

    teleop_velocity_watchdog #(
        .MAX_SESSIONS (SESSIONS_MAX)
    )
    u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tvw_checker #(
        .MAX_SESSIONS (SESSIONS_MAX)
    )
    u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // Receiver side: alternate stall bursts with open runs, some of them long;
    // hold stall low whenever quiet is set.
    always @(posedge clk)
    begin
        if (quiet)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (res_stall)
        begin
            res_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 40);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
    end

    // Count cycles with no transfer on either channel; end a hung run.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one event and hold it until it transfers. Optionally drop valid for
    // a gap first, so gaps land between any two events.
    task automatic send_event(input logic [2:0] code, input logic signed [15:0] lin,
                              input logic signed [15:0] ang);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_data.cmd        <= code;
        cmd_data.linear_in  <= lin;
        cmd_data.angular_in <= ang;
        cmd_valid           <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        events_sent++;
    endtask

    // Speeds aimed at the clamp edges, the field extremes, small values around zero, or anywhere
    function automatic logic signed [15:0] pick_speed(input logic [14:0] lim);
        logic signed [16:0] bound_v;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1:
            begin
                bound_v = {2'b00, lim};
                bound_v = bound_v + 17'($urandom_range(0, 6)) - 17'd3;
                if ($urandom_range(0, 1) == 1)
                    bound_v = -bound_v;
                return bound_v[15:0];
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: return 16'($urandom_range(0, 1023)) - 16'd512;
        endcase
    endfunction

    task automatic send_plain(input logic [2:0] code);
        send_event(code, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_velocity();
        send_event(tvw_pkg::CMD_VELOCITY, pick_speed(lim_lin), pick_speed(lim_ang));
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_plain(tvw_pkg::CMD_TICK);
    endtask

    // Drop valid, wait until every predicted result has transferred, then
    // let the two-stage pipeline empty.
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tvw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tvw_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write all four registers back to back; the unused upper data bits carry
    // random junk that the block must ignore. Call only when idle.
    task automatic program_limits(input logic [14:0] ml, input logic [14:0] ma,
                                  input logic rev, input logic [15:0] wd);
        write_reg(tvw_pkg::REG_MAX_LINEAR, {1'($urandom), ml});
        write_reg(tvw_pkg::REG_MAX_ANGULAR, {1'($urandom), ma});
        write_reg(tvw_pkg::REG_REVERSE_EN, {15'($urandom), rev});
        write_reg(tvw_pkg::REG_WATCHDOG_TICKS, wd);
        cfg_wr_en <= 1'b0;
        lim_lin = ml;
        lim_ang = ma;
        cur_wd  = wd;
        @(posedge clk);
    endtask

    // One well-formed session: open, a few command/tick rounds aimed around
    // the freshness window, then close (sometimes one too few or too many).
    task automatic session_script();
        int opens;
        int rounds;
        int run_len;
        int stops;
        opens  = $urandom_range(1, 3);
        rounds = $urandom_range(1, 4);
        repeat (opens) send_plain(tvw_pkg::CMD_SESSION_START);
        repeat (rounds)
        begin
            if ($urandom_range(0, 4) == 0)
                send_plain(tvw_pkg::CMD_CLEAR);
            else
                send_velocity();
            run_len = $urandom_range(0, (cur_wd < 12) ? int'(cur_wd) + 3 : 14);
            send_ticks(run_len);
            // Run past the window now and then to reach the zero publish
            if (cur_wd < 40 && $urandom_range(0, 3) == 0)
                send_ticks(int'(cur_wd) + 2);
        end
        stops = opens + $urandom_range(0, 2) - 1;
        repeat (stops) send_plain(tvw_pkg::CMD_SESSION_STOP);
    endtask

    // Mostly session scripts with random content, plus raw noise events that
    // include the undefined codes.
    task automatic run_traffic(input int count);
        int target;
        int code;
        target = events_sent + count;
        while (events_sent < target)
        begin
            if ($urandom_range(0, 99) < 75)
                session_script();
            else
            begin
                code = $urandom_range(0, 7);
                if (code == int'(tvw_pkg::CMD_VELOCITY))
                    send_velocity();
                else
                    send_plain(3'(code));
            end
        end
    endtask

    task automatic run_phase(input logic [14:0] ml, input logic [14:0] ma, input logic rev,
                             input logic [15:0] wd, input int count, input logic calm,
                             input int gaps);
        settle();
        quiet <= calm;
        gap_pct = gaps;
        program_limits(ml, ma, rev, wd);
        run_traffic(count);
    endtask

    initial
    begin : stimulus
        // Hold reset, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: 256/256, no reverse, 500-tick window
        send_plain(tvw_pkg::CMD_TICK);                 // tick with nothing open
        send_plain(tvw_pkg::CMD_SESSION_STOP);         // stop with no session
        send_event(tvw_pkg::CMD_VELOCITY, 16'sd100, -16'sd50);  // held without session
        send_plain(tvw_pkg::CMD_TICK);
        send_plain(tvw_pkg::CMD_SESSION_START);
        send_plain(tvw_pkg::CMD_TICK);                 // fresh: republish
        send_event(tvw_pkg::CMD_VELOCITY, 16'sh7FFF, 16'sh8000);
        send_event(tvw_pkg::CMD_VELOCITY, 16'sh8000, 16'sh7FFF); // reverse blocked
        send_plain(tvw_pkg::CMD_TICK);
        send_plain(tvw_pkg::CMD_CLEAR);
        send_plain(tvw_pkg::CMD_TICK);                 // zero already sent
        send_plain(3'd5);                              // undefined codes
        send_plain(3'd6);
        send_plain(3'd7);
        send_plain(tvw_pkg::CMD_SESSION_STOP);

        // Widest limits, reverse on, zero-length window: first tick is stale
        settle();
        program_limits(15'h7FFF, 15'h7FFF, 1'b1, 16'd0);
        send_plain(tvw_pkg::CMD_SESSION_START);
        send_event(tvw_pkg::CMD_VELOCITY, 16'sh8000, 16'sh8000);
        send_plain(tvw_pkg::CMD_TICK);
        send_plain(tvw_pkg::CMD_TICK);
        send_event(tvw_pkg::CMD_VELOCITY, 16'sh7FFF, 16'sh7FFF);
        send_plain(tvw_pkg::CMD_SESSION_START);
        send_plain(tvw_pkg::CMD_SESSION_STOP);         // one session still open
        send_plain(tvw_pkg::CMD_SESSION_STOP);

        // Zero limits, one-tick window: fresh exactly at the window, then stale
        settle();
        program_limits(15'd0, 15'd0, 1'b0, 16'd1);
        send_plain(tvw_pkg::CMD_SESSION_START);
        send_event(tvw_pkg::CMD_VELOCITY, 16'sd1, -16'sd1);
        send_plain(tvw_pkg::CMD_TICK);
        send_plain(tvw_pkg::CMD_TICK);
        send_plain(tvw_pkg::CMD_SESSION_STOP);

        // Session counter saturation and a short window, with idling off
        settle();
        quiet <= 1'b1;
        gap_pct = 0;
        program_limits(15'd300, 15'd300, 1'b0, 16'd6);
        repeat (SESSIONS_MAX + 2) send_plain(tvw_pkg::CMD_SESSION_START);
        send_velocity();
        repeat (SESSIONS_MAX + 1) send_plain(tvw_pkg::CMD_SESSION_STOP);
        send_plain(tvw_pkg::CMD_SESSION_START);
        send_velocity();
        send_ticks(6);                                 // still fresh at the window
        send_plain(tvw_pkg::CMD_TICK);                 // one past: publish zero
        send_plain(tvw_pkg::CMD_SESSION_STOP);
        // Timer runs on with no session open; the first tick after opening is stale
        send_velocity();
        send_ticks(9);
        send_plain(tvw_pkg::CMD_SESSION_START);
        send_plain(tvw_pkg::CMD_TICK);
        send_plain(tvw_pkg::CMD_SESSION_STOP);

        // Random traffic over several limit settings; last phase without idling
        run_phase(15'($urandom), 15'($urandom), 1'($urandom), 16'($urandom_range(0, 20)),
                  45, 1'b0, 20);
        run_phase(15'd0, 15'h7FFF, 1'b1, 16'd3, 40, 1'b0, 25);
        run_phase(15'h7FFF, 15'd0, 1'b0, 16'd0, 40, 1'b0, 0);
        run_phase(15'($urandom), 15'($urandom), 1'b1, 16'($urandom_range(0, 30)),
                  40, 1'b0, 30);
        run_phase(tvw_pkg::MAX_LINEAR_RST, tvw_pkg::MAX_ANGULAR_RST,
                  tvw_pkg::REVERSE_EN_RST, tvw_pkg::WATCHDOG_TICKS_RST, 40, 1'b0, 15);
        run_phase(15'($urandom), 15'($urandom), 1'($urandom), 16'($urandom_range(0, 10)),
                  45, 1'b1, 0);

        // Drain everything, then give the verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tvw_pkg.sv
sv/tvw_cfg_regs.sv
sv/tvw_core.sv
sv/teleop_velocity_watchdog.sv
sv/tvw_checker.sv
tb/sv/tvw_checker.sv
tb/sv/tb_top.sv
